### design/tcfd_pkg.sv
`default_nettype none
package tcfd_pkg;

	localparam int DistW = 24;
	localparam int FracB = 16;
	localparam int CosW = FracB + 2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DOMAIN = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		logic [DistW-1:0] dist_p3_p2;
		logic [DistW-1:0] dist_p3_p1;
		logic [DistW-1:0] dist_p3_p0;
		logic [DistW-1:0] dist_p2_p1;
		logic [DistW-1:0] dist_p2_p0;
		logic [DistW-1:0] dist_p1_p0;
	} in_beat_t;

	typedef struct packed {
		logic signed [CosW-1:0] cos_torsion;
		logic [1:0]             status;
	} out_beat_t;

endpackage
`default_nettype wire

### design/tcfd_div_cell.sv
`default_nettype none
// one restoring quotient bit per cell, payload rides alongside
module tcfd_div_cell #(
	parameter int NW = 52,
	parameter int QW = 18,
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_i,
	input  wire logic [NW-1:0] n_i,
	input  wire logic [NW-1:0] d_i,
	input  wire logic [QW-1:0] q_i,
	input  wire logic [PW-1:0] p_i,
	output logic               vld_o,
	output logic [NW-1:0]      n_o,
	output logic [NW-1:0]      d_o,
	output logic [QW-1:0]      q_o,
	output logic [PW-1:0]      p_o
);
	logic [NW-1:0] t;
	logic          ge;
	assign t  = {n_i[NW-2:0], 1'b0};
	assign ge = t >= d_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_o <= ge ? t - d_i : t;
			d_o <= d_i;
			q_o <= {q_i[QW-2:0], ge};
			p_o <= p_i;
		end
	end
endmodule
`default_nettype wire

### design/tcfd_sqrt_cell.sv
`default_nettype none
// one result bit of a digit-by-digit square root per cell
module tcfd_sqrt_cell #(
	parameter int RW = 17,
	parameter int SH = 0,
	parameter int PW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vld_i,
	input  wire logic [2*RW-1:0] v_i,
	input  wire logic [RW-1:0]   r_i,
	input  wire logic [PW-1:0]   p_i,
	output logic                 vld_o,
	output logic [2*RW-1:0]      v_o,
	output logic [RW-1:0]        r_o,
	output logic [PW-1:0]        p_o
);
	logic [RW-1:0]   rt;
	logic [2*RW-1:0] sq;
	assign rt = r_i | (RW'(1) << SH);
	assign sq = (2*RW)'(rt) * (2*RW)'(rt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_o <= v_i;
			r_o <= (sq <= v_i) ? rt : r_i;
			p_o <= p_i;
		end
	end
endmodule
`default_nettype wire

### design/torsion_cosine_from_distances.sv
`default_nettype none
// depth: 3*FracB+6 register stages from the input beat to out
// throughput: one beat per cycle; a stall on out freezes the whole chain
// one bit per cell in the cosine-rule dividers, the square-root chains and the final divider
// reset: arst_n clears all valid bits; payload registers are not reset
module torsion_cosine_from_distances (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tcfd_pkg::in_beat_t in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tcfd_pkg::out_beat_t     out
);
	import tcfd_pkg::*;

	localparam int F  = FracB;
	localparam int NW = 2*DistW + 4;
	localparam int QW = F + 2;
	localparam int RW = F + 1;
	localparam int DW = 2*RW + 2;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: squares and products
	logic           v1_s1;
	logic [NW-1:0]  num_s1 [3];
	logic [NW-1:0]  den_s1 [3];
	logic [2:0]     neg_s1;
	logic           z_s1;

	function automatic logic [NW-1:0] sq(input logic [DistW-1:0] x);
		sq = NW'(x) * NW'(x);
	endfunction

	logic [NW-1:0] s_a, s_b, s_c, zz_a, zz_b, zz_c;
	always_comb begin
		s_a = sq(in.dist_p3_p2) + sq(in.dist_p2_p0); zz_a = sq(in.dist_p3_p0);
		s_b = sq(in.dist_p2_p0) + sq(in.dist_p2_p1); zz_b = sq(in.dist_p1_p0);
		s_c = sq(in.dist_p3_p2) + sq(in.dist_p2_p1); zz_c = sq(in.dist_p3_p1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_s1 <= 1'b0;
		else if (en) v1_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= {zz_c > s_c, zz_b > s_b, zz_a > s_a};
			num_s1[0] <= (zz_a > s_a) ? zz_a - s_a : s_a - zz_a;
			num_s1[1] <= (zz_b > s_b) ? zz_b - s_b : s_b - zz_b;
			num_s1[2] <= (zz_c > s_c) ? zz_c - s_c : s_c - zz_c;
			den_s1[0] <= {NW'(in.dist_p3_p2) * NW'(in.dist_p2_p0)} << 1;
			den_s1[1] <= {NW'(in.dist_p2_p0) * NW'(in.dist_p2_p1)} << 1;
			den_s1[2] <= {NW'(in.dist_p3_p2) * NW'(in.dist_p2_p1)} << 1;
			z_s1 <= in.dist_p3_p2 == '0 || in.dist_p2_p0 == '0 || in.dist_p2_p1 == '0;
		end
	end

	// stage 2: integer bit and saturation
	logic           v_s2;
	logic [NW-1:0]  n_s2 [3];
	logic [NW-1:0]  d_s2 [3];
	logic [QW-1:0]  q_s2 [3];
	logic [2:0]     sat_s2, neg_s2;
	logic           z_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v1_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sat_s2[i] <= num_s1[i] >= {den_s1[i][NW-2:0], 1'b0};
				if (num_s1[i] >= den_s1[i]) begin
					n_s2[i] <= num_s1[i] - den_s1[i];
					q_s2[i] <= QW'(1);
				end else begin
					n_s2[i] <= num_s1[i];
					q_s2[i] <= '0;
				end
				d_s2[i] <= den_s1[i];
			end
			neg_s2 <= neg_s1;
			z_s2 <= z_s1;
		end
	end

	// three divider chains of F cells
	localparam int P1 = 7;
	logic           cv   [3][F+1];
	logic [NW-1:0]  cn   [3][F+1];
	logic [NW-1:0]  cd   [3][F+1];
	logic [QW-1:0]  cq   [3][F+1];
	logic [P1-1:0]  cp   [3][F+1];

	for (genvar k = 0; k < 3; k++) begin : g_cr
		assign cv[k][0] = v_s2;
		assign cn[k][0] = n_s2[k];
		assign cd[k][0] = d_s2[k];
		assign cq[k][0] = q_s2[k];
		assign cp[k][0] = {z_s2, sat_s2, neg_s2};
		for (genvar j = 0; j < F; j++) begin : g_c
			tcfd_div_cell #(.NW(NW), .QW(QW), .PW(P1)) u_cell (
				.clk, .arst_n, .en,
				.vld_i(cv[k][j]), .n_i(cn[k][j]), .d_i(cd[k][j]),
				.q_i(cq[k][j]), .p_i(cp[k][j]),
				.vld_o(cv[k][j+1]), .n_o(cn[k][j+1]), .d_o(cd[k][j+1]),
				.q_o(cq[k][j+1]), .p_o(cp[k][j+1])
			);
		end
	end

	// stage 3: signed cosines, radicands
	logic                  v_s3;
	logic signed [QW:0]    a_s3, b_s3, c_s3;
	logic [1:0]            st_s3;
	logic [2*RW-1:0]       rb_s3, rc_s3;
	logic [QW-1:0]         m [3];
	logic [P1-1:0]         pp;
	assign pp = cp[0][F];
	always_comb begin
		for (int i = 0; i < 3; i++)
			m[i] = pp[3+i] ? QW'(1) << (F+1) : cq[i][F];
	end
	logic [QW-1:0] one_q;
	assign one_q = QW'(1) << F;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= cv[0][F];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= pp[0] ? -$signed({1'b0, m[0]}) : $signed({1'b0, m[0]});
			b_s3 <= pp[1] ? -$signed({1'b0, m[1]}) : $signed({1'b0, m[1]});
			c_s3 <= pp[2] ? -$signed({1'b0, m[2]}) : $signed({1'b0, m[2]});
			if (pp[6]) st_s3 <= ST_DIV0;
			else if (m[1] > one_q || m[2] > one_q) st_s3 <= ST_DOMAIN;
			else st_s3 <= ST_OK;
			rb_s3 <= ((2*RW)'(1) << (2*F)) - (2*RW)'(m[1][RW-1:0]) * (2*RW)'(m[1][RW-1:0]);
			rc_s3 <= ((2*RW)'(1) << (2*F)) - (2*RW)'(m[2][RW-1:0]) * (2*RW)'(m[2][RW-1:0]);
		end
	end

	// square-root chains; the first carries the numerator a - b*c and status
	localparam int P2 = 2*QW + 4 + 2;
	logic signed [2*QW+3:0] bc;
	assign bc = (2*QW+4)'(b_s3) * (2*QW+4)'(c_s3);
	logic signed [2*QW+3:0] an;
	assign an = (2*QW+4)'(a_s3) <<< F;
	logic            sv  [2][RW+1];
	logic [2*RW-1:0] svv [2][RW+1];
	logic [RW-1:0]   sr  [2][RW+1];
	logic [P2-1:0]   spl [2][RW+1];
	assign sv[0][0] = v_s3; assign sv[1][0] = v_s3;
	assign svv[0][0] = rb_s3; assign svv[1][0] = rc_s3;
	assign sr[0][0] = '0; assign sr[1][0] = '0;
	assign spl[0][0] = {an - bc, st_s3};
	assign spl[1][0] = '0;
	for (genvar k = 0; k < 2; k++) begin : g_sq
		for (genvar j = 0; j < RW; j++) begin : g_c
			tcfd_sqrt_cell #(.RW(RW), .SH(RW-1-j), .PW(P2)) u_cell (
				.clk, .arst_n, .en,
				.vld_i(sv[k][j]), .v_i(svv[k][j]), .r_i(sr[k][j]), .p_i(spl[k][j]),
				.vld_o(sv[k][j+1]), .v_o(svv[k][j+1]), .r_o(sr[k][j+1]),
				.p_o(spl[k][j+1])
			);
		end
	end

	// stage 4: divisor and numerator magnitude
	logic                v_s4;
	logic [NW-1:0]       n_s4, d_s4;
	logic                sg_s4, sat_s4;
	logic [1:0]          st_s4;
	logic signed [2*QW+3:0] nm;
	logic [DW-1:0]       dv;
	assign nm = spl[0][RW][P2-1:2];
	assign dv = DW'(sr[0][RW]) * DW'(sr[1][RW]);
	logic [NW-1:0] na;
	assign na = nm[2*QW+3] ? NW'(-nm) : NW'(nm);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sv[0][RW];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s4 <= nm[2*QW+3];
			if (spl[0][RW][1:0] != ST_OK) st_s4 <= spl[0][RW][1:0];
			else if (dv == '0) st_s4 <= ST_DIV0;
			else st_s4 <= ST_OK;
			sat_s4 <= na >= NW'(dv) << 1;
			n_s4 <= (na >= NW'(dv)) ? na - NW'(dv) : na;
			d_s4 <= NW'(dv);
		end
	end
	logic [QW-1:0] q4_0;
	assign q4_0 = '0;

	// final divider chain
	localparam int P3 = 4;
	logic          fv [F+1];
	logic [NW-1:0] fn [F+1];
	logic [NW-1:0] fd [F+1];
	logic [QW-1:0] fq [F+1];
	logic [P3-1:0] fp [F+1];
	logic          ge0_s4;
	always_ff @(posedge clk) begin
		if (en) ge0_s4 <= na >= NW'(dv);
	end
	assign fv[0] = v_s4; assign fn[0] = n_s4; assign fd[0] = d_s4;
	assign fq[0] = q4_0 | QW'(ge0_s4);
	assign fp[0] = {sg_s4, sat_s4, st_s4};
	for (genvar j = 0; j < F; j++) begin : g_fd
		tcfd_div_cell #(.NW(NW), .QW(QW), .PW(P3)) u_cell (
			.clk, .arst_n, .en,
			.vld_i(fv[j]), .n_i(fn[j]), .d_i(fd[j]), .q_i(fq[j]), .p_i(fp[j]),
			.vld_o(fv[j+1]), .n_o(fn[j+1]), .d_o(fd[j+1]), .q_o(fq[j+1]),
			.p_o(fp[j+1])
		);
	end

	// output register
	logic [QW-1:0] mg;
	assign mg = (fp[F][2] || fq[F] > one_q) ? one_q : fq[F];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= fv[F];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out.status <= fp[F][1:0];
			if (fp[F][1:0] != ST_OK) out.cos_torsion <= '0;
			else out.cos_torsion <= fp[F][3] ? -$signed(mg) : $signed(mg);
		end
	end

	logic unused;
	assign unused = ^{svv[0][RW], svv[1][RW], spl[1][RW],
		cn[0][F], cd[0][F], cn[1][F], cd[1][F], cn[2][F], cd[2][F], cp[1][F], cp[2][F],
		cv[1][F], cv[2][F], sv[1][RW], fn[F], fd[F]};

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out.status == ST_OK || out.status == ST_DOMAIN || out.status == ST_DIV0)
		else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out.status != ST_OK |-> out.cos_torsion == '0) else $error("err nonzero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out)) else $error("out moved");
endmodule
`default_nettype wire
